FILE: sv/sse_pkg.sv
// Shared codes and types for the sorted set engine.
`default_nettype none
package sse_pkg;

    // Operation codes carried on the input tuser.
    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_NOP    = 2'd3
    } t_kind;

    // Result status codes carried on the output tuser.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 4;

    // Outcome of one signed comparison of a stored word against the operand.
    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

endpackage
`default_nettype wire

FILE: sv/sse_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module sse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

FILE: sv/sse_cmp.sv
// Shared signed comparator used by the compare step of the sequencer.
`default_nettype none
module sse_cmp (
    input  wire logic [sse_pkg::VALUE_W-1:0] i_a,
    input  wire logic [sse_pkg::VALUE_W-1:0] i_b,
    output sse_pkg::t_cmp                    o_cmp
);
    import sse_pkg::*;

    // The stored word against the operand, in signed order.
    always_comb begin
        o_cmp.lt = $signed(i_a) < $signed(i_b);
        o_cmp.eq = (i_a == i_b);
    end

endmodule
`default_nettype wire

FILE: sv/sorted_set_engine.sv
// Top level of the sorted set engine: sequencer, entry RAM and comparator.
//
// The block keeps up to CAPACITY distinct signed 32-bit values in ascending
// order in a RAM. An operation beat enters on the s_axis channel (kind on
// tuser, value on tdata); one result beat leaves on the m_axis channel
// (status on tuser, position and removed value on tdata).
// A small sequencer walks the RAM one entry at a time; every visited entry
// passes the bound check S_CHK, which issues the read, and then S_CMP
// (compare through the shared comparator and write back), set by the single
// read port and its registered data. A search stops at its first matching
// entry, and an unused kind goes straight to the result step.
// s_axis_tready is high only while the sequencer is idle, so the next beat
// is taken in the cycle after the result is loaded at the earliest.
// The result sits in an output register; while the receiver stalls a new
// item may still be accepted, and it waits in its last step until the
// output register is free. Reset empties the store at once (count cleared);
// no clearing pass is needed, entries above count are never read.
`default_nettype none
module sorted_set_engine #(
    parameter int CAPACITY = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [3:0] position, [35:4] removed_value, rest zero
    output logic [2:0]       m_axis_tuser    // [2:0] status
);
    import sse_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHK,
        S_CMP,
        S_FIN
    } t_state;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_idx, n_idx;
    logic                 r_phase, n_phase;
    t_kind                r_kind, n_kind;
    logic [VALUE_W-1:0]   r_val, n_val;
    logic [VALUE_W-1:0]   r_carry, n_carry;
    t_status              r_status, n_status;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [VALUE_W-1:0]   r_removed, n_removed;
    logic                 r_m_valid, n_m_valid;
    t_status              r_m_status, n_m_status;
    logic [POS_W-1:0]     r_m_pos, n_m_pos;
    logic [VALUE_W-1:0]   r_m_removed, n_m_removed;

    logic                 wr_en;
    logic [CW-1:0]        wr_idx;
    logic [VALUE_W-1:0]   wr_data;
    logic [VALUE_W-1:0]   rd_data;
    t_cmp                 cmp;
    logic                 accept;

    // Entry store.
    sse_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_idx[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // Shared comparator: stored word against the operand.
    sse_cmp u_cmp (
        .i_a   (rd_data),
        .i_b   (r_val),
        .o_cmp (cmp)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = {4'd0, r_m_removed, r_m_pos};

    // Sequencer next-state logic and RAM write port.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_phase     = r_phase;
        n_kind      = r_kind;
        n_val       = r_val;
        n_carry     = r_carry;
        n_status    = r_status;
        n_pos       = r_pos;
        n_removed   = r_removed;
        n_m_valid   = r_m_valid;
        n_m_status  = r_m_status;
        n_m_pos     = r_m_pos;
        n_m_removed = r_m_removed;
        wr_en       = 1'b0;
        wr_idx      = r_idx;
        wr_data     = r_val;

        // The output register empties when the receiver takes the beat.
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind    = t_kind'(s_axis_tuser);
                    n_val     = s_axis_tdata;
                    n_idx     = '0;
                    n_phase   = 1'b0;
                    n_status  = ST_OK;
                    n_pos     = '0;
                    n_removed = '0;
                    n_state   = (t_kind'(s_axis_tuser) == KIND_NOP) ? S_FIN : S_CHK;
                end
            end

            // Bound check; the RAM samples the read address in this cycle.
            S_CHK: begin
                case (r_kind)
                    KIND_INSERT: begin
                        if (r_idx == r_count) begin
                            if (!r_phase && r_count == CAP) begin
                                n_status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_data = r_phase ? r_carry : r_val;
                                n_count = r_count + 1'b1;
                            end
                            n_state = S_FIN;
                        end else begin
                            n_state = S_CMP;
                        end
                    end
                    KIND_REMOVE: begin
                        if (!r_phase && r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_FIN;
                        end else if (r_phase && r_idx == r_count) begin
                            n_count = r_count - 1'b1;
                            n_state = S_FIN;
                        end else begin
                            n_state = S_CMP;
                        end
                    end
                    KIND_SEARCH: begin
                        if (r_idx == r_count) begin
                            n_status = ST_NOTFOUND;
                            n_state  = S_FIN;
                        end else begin
                            n_state = S_CMP;
                        end
                    end
                    default: n_state = S_FIN;
                endcase
            end

            // Read data is here: compare, shift and advance.
            S_CMP: begin
                n_state = S_CHK;
                case (r_kind)
                    KIND_INSERT: begin
                        if (r_phase) begin
                            // Ripple the displaced entry one place up.
                            wr_en   = 1'b1;
                            wr_data = r_carry;
                            n_carry = rd_data;
                            n_idx   = r_idx + 1'b1;
                        end else if (cmp.lt) begin
                            n_idx = r_idx + 1'b1;
                        end else if (cmp.eq) begin
                            n_status = ST_DUP;
                            n_state  = S_FIN;
                        end else if (r_count == CAP) begin
                            n_status = ST_FULL;
                            n_state  = S_FIN;
                        end else begin
                            wr_en   = 1'b1;
                            wr_data = r_val;
                            n_carry = rd_data;
                            n_phase = 1'b1;
                            n_idx   = r_idx + 1'b1;
                        end
                    end
                    KIND_REMOVE: begin
                        if (r_phase) begin
                            // Move each entry one place down.
                            wr_en   = 1'b1;
                            wr_idx  = r_idx - 1'b1;
                            wr_data = rd_data;
                        end else begin
                            n_removed = rd_data;
                            n_phase   = 1'b1;
                        end
                        n_idx = r_idx + 1'b1;
                    end
                    KIND_SEARCH: begin
                        if (cmp.eq) begin
                            n_pos   = POS_W'(r_idx);
                            n_state = S_FIN;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                    default: n_state = S_FIN;
                endcase
            end

            // Hand the result to the output register once it is free.
            S_FIN: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid   = 1'b1;
                    n_m_status  = r_status;
                    n_m_pos     = r_pos;
                    n_m_removed = r_removed;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_phase     <= n_phase;
        r_kind      <= n_kind;
        r_val       <= n_val;
        r_carry     <= n_carry;
        r_status    <= n_status;
        r_pos       <= n_pos;
        r_removed   <= n_removed;
        r_m_status  <= n_m_status;
        r_m_pos     <= n_m_pos;
        r_m_removed <= n_m_removed;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
    end

endmodule
`default_nettype wire
